### rtl/image_convolution_2d_top_macros.svh
`ifndef IMAGE_CONVOLUTION_2D_TOP_MACROS_SVH
`define IMAGE_CONVOLUTION_2D_TOP_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define IC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/imconv_pkg.sv
`timescale 1ns / 1ps

package imconv_pkg;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [1:0] CFG_IMAGE_SIDE  = 2'd0;
  localparam logic [1:0] CFG_KERNEL_SIDE = 2'd1;
  localparam logic [1:0] CFG_GAIN        = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pixel_value;
    logic [4:0]         coeff_index;
    logic signed [15:0] coeff_value;
  } in_req_t;

  typedef struct packed {
    logic signed [35:0] filtered_value;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic               last_of_run;
    logic               last_of_image;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STORE,
    ST_WIN,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_DVS,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

### rtl/image_convolution_2d_top.sv
// channel   | valid      | stall       | payload
// ----------+------------+-------------+-----------------------
// request   | in_valid_i | in_stall_o  | in_req_i  (in_req_t)
// result    | out_valid_o| out_stall_i | out_rsp_o (out_rsp_t)
// config    | cfg_we_i   | -           | cfg_idx_i, cfg_data_i
// Load and ignored requests do not leave idle; a pixel or flush is stored, then for
// each output pixel the window taps pass through the shared multiply-accumulate and
// then the divider and the output register, up to 3 outputs per request.
// Reset clears counters and coefficients and sets config to defaults; the line store is not cleared.
// A stalled result holds in the output register; once its run has ended, the next request is taken meanwhile.
`timescale 1ns / 1ps

`include "image_convolution_2d_top_macros.svh"

module image_convolution_2d_top
  import imconv_pkg::*;
#(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_IMAGE  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_rsp_t    out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int KK    = MAX_KERNEL * MAX_KERNEL;
  localparam int NW    = $clog2(MAX_IMAGE + MAX_KERNEL);
  localparam int PW    = NW + 1;
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int SLW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CIW   = (KK > 1) ? $clog2(KK) : 1;
  localparam int AW    = $clog2(MAX_KERNEL * MAX_IMAGE);
  localparam int DEPTH = MAX_KERNEL * MAX_IMAGE;
  localparam int ACC_W = 33 + $clog2(KK + 1);
  localparam int CNW   = $clog2(ACC_W);

  state_e state_q, state_d;

  logic [8:0]  img_side_q;
  logic [2:0]  ker_side_q;
  logic [15:0] gain_q;

  logic signed [15:0] coef_q [KK];
  logic signed [15:0] mem [DEPTH];

  logic [NW-1:0]  row_q, col_q;
  logic [SLW-1:0] slot_q;

  logic [1:0]         op_q;
  logic signed [15:0] pix_q;
  logic [NW-1:0]      orow_q, oc_q, hi_q;
  logic [SLW-1:0]     base_q, rslot_q;
  logic signed [PW-1:0] pr_q, pc_q;
  logic [KW-1:0]      i_q, j_q;
  logic [CIW-1:0]     ti_q;
  logic               tap_ok_q;
  logic signed [15:0] rd_q, cf_q;
  logic signed [31:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]   mag_q;
  logic               neg_q;
  logic [15:0]        rem_q;
  logic [CNW-1:0]     cnt_q;

  logic     out_valid_q;
  out_rsp_t out_rsp_q, out_rsp_d;

  logic [NW-1:0] side, spad;
  logic [KW-1:0] kmin, kside, pad;
  logic [15:0]   g;
  logic          in_acc, is_px, restart;
  logic          rowok, c_last, c_ge, any_out;
  logic [NW-1:0] lo, hi;
  logic [SLW:0]  bsum;
  logic [AW-1:0] waddr, raddr;
  logic [16:0]   trial;
  logic          ge;
  logic          last_tap, out_ld;
  logic [ACC_W-1:0] quot;

  always_comb begin
    if (img_side_q == 9'd0) begin
      side = NW'(1);
    end else if (32'(img_side_q) > MAX_IMAGE) begin
      side = NW'(MAX_IMAGE);
    end else begin
      side = NW'(img_side_q);
    end
    kmin = (32'(ker_side_q) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(ker_side_q);
    if (kmin[0]) begin
      kside = kmin;
    end else if (kmin == '0) begin
      kside = KW'(1);
    end else begin
      kside = kmin - KW'(1);
    end
    pad  = kside >> 1;
    spad = side + NW'(pad);
    g    = (gain_q == 16'd0) ? 16'd1 : gain_q;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign is_px      = (in_req_i.operation == OP_PIXEL) || (in_req_i.operation == OP_FLUSH);
  assign restart    = (col_q >= side) || (row_q >= spad);

  assign rowok   = row_q >= NW'(pad);
  assign c_last  = col_q == (side - NW'(1));
  assign c_ge    = col_q >= NW'(pad);
  assign any_out = rowok && (c_last || c_ge);
  assign lo      = (c_last && !c_ge) ? '0 : (col_q - NW'(pad));
  assign hi      = c_last ? (side - NW'(1)) : (col_q - NW'(pad));
  assign bsum    = {1'b0, slot_q} + (SLW+1)'(MAX_KERNEL) - (SLW+1)'({pad, 1'b0});

  assign waddr = AW'(slot_q) * AW'(MAX_IMAGE) + AW'(col_q);
  assign raddr = AW'(rslot_q) * AW'(MAX_IMAGE) + AW'(unsigned'(pc_q));

  assign last_tap = (i_q == kside - KW'(1)) && (j_q == kside - KW'(1));
  assign trial    = {rem_q, mag_q[ACC_W-1]};
  assign ge       = trial >= {1'b0, g};
  assign out_ld   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign quot     = neg_q ? (~mag_q + ACC_W'(1)) : mag_q;

  always_comb begin
    out_rsp_d.filtered_value = signed'(quot[35:0]);
    out_rsp_d.out_row        = 8'(orow_q);
    out_rsp_d.out_col        = 8'(oc_q);
    out_rsp_d.last_of_run    = (oc_q == hi_q);
    out_rsp_d.last_of_image  = (orow_q == side - NW'(1)) && (oc_q == side - NW'(1));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && is_px) state_d = ST_STORE;
      ST_STORE: state_d = any_out ? ST_WIN : ST_IDLE;
      ST_WIN:   state_d = ST_RD;
      ST_RD:    state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = last_tap ? ST_DVS : ST_RD;
      ST_DVS:   state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CNW'(ACC_W - 1)) state_d = ST_OUT;
      ST_OUT:   if (out_ld) state_d = (oc_q == hi_q) ? ST_IDLE : ST_WIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      img_side_q  <= 9'd256;
      ker_side_q  <= 3'd3;
      gain_q      <= 16'd1;
      row_q       <= '0;
      col_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      for (int n = 0; n < KK; n++) coef_q[n] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_SIDE:  img_side_q <= cfg_data_i[8:0];
          CFG_KERNEL_SIDE: ker_side_q <= cfg_data_i[2:0];
          CFG_GAIN:        gain_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && in_req_i.operation == OP_LOAD && 32'(in_req_i.coeff_index) < KK) begin
        coef_q[CIW'(in_req_i.coeff_index)] <= in_req_i.coeff_value;
      end
      if (in_acc && is_px && restart) begin
        row_q  <= '0;
        col_q  <= '0;
        slot_q <= '0;
      end else if (state_q == ST_STORE) begin
        if (col_q + NW'(1) >= side) begin
          col_q <= '0;
          if (row_q + NW'(1) >= spad) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + NW'(1);
            slot_q <= (slot_q == SLW'(MAX_KERNEL - 1)) ? '0 : slot_q + SLW'(1);
          end
        end else begin
          col_q <= col_q + NW'(1);
        end
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_STORE) begin
      mem[waddr] <= (op_q == OP_PIXEL) ? pix_q : 16'sd0;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_req_i.operation;
      pix_q <= in_req_i.pixel_value;
    end
    case (state_q)
      ST_STORE: begin
        orow_q <= row_q - NW'(pad);
        oc_q   <= lo;
        hi_q   <= hi;
        base_q <= (bsum >= (SLW+1)'(MAX_KERNEL)) ? SLW'(bsum - (SLW+1)'(MAX_KERNEL))
                                                 : SLW'(bsum);
      end
      ST_WIN: begin
        pr_q    <= signed'(PW'(orow_q)) - signed'(PW'(pad));
        pc_q    <= signed'(PW'(oc_q)) - signed'(PW'(pad));
        i_q     <= '0;
        j_q     <= '0;
        ti_q    <= '0;
        rslot_q <= base_q;
        acc_q   <= '0;
      end
      ST_RD: begin
        tap_ok_q <= (pr_q >= 0) && (pr_q < signed'(PW'(side))) &&
                    (pc_q >= 0) && (pc_q < signed'(PW'(side)));
        cf_q     <= coef_q[ti_q];
      end
      ST_MUL: begin
        prod_q <= tap_ok_q ? (32'(rd_q) * 32'(cf_q)) : 32'sd0;
      end
      ST_ACC: begin
        acc_q <= acc_q + ACC_W'(prod_q);
        ti_q  <= ti_q + CIW'(1);
        if (j_q == kside - KW'(1)) begin
          j_q     <= '0;
          i_q     <= i_q + KW'(1);
          pc_q    <= signed'(PW'(oc_q)) - signed'(PW'(pad));
          pr_q    <= pr_q + PW'(1);
          rslot_q <= (rslot_q == SLW'(MAX_KERNEL - 1)) ? '0 : rslot_q + SLW'(1);
        end else begin
          j_q  <= j_q + KW'(1);
          pc_q <= pc_q + PW'(1);
        end
      end
      ST_DVS: begin
        neg_q <= acc_q[ACC_W-1];
        mag_q <= acc_q[ACC_W-1] ? (~unsigned'(acc_q) + ACC_W'(1)) : unsigned'(acc_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= ge ? 16'(trial - {1'b0, g}) : trial[15:0];
        mag_q <= {mag_q[ACC_W-2:0], ge};
        cnt_q <= cnt_q + CNW'(1);
      end
      ST_OUT: begin
        if (out_ld) begin
          out_rsp_q <= out_rsp_d;
          if (oc_q != hi_q) oc_q <= oc_q + NW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `IC_ASSERT_NOW(a_div_count, state_q == ST_DIV, 32'(cnt_q) < ACC_W, "divider overran")
  `IC_ASSERT_NOW(a_tap_index, state_q == ST_ACC, 32'(ti_q) < KK, "tap index out of range")
  `IC_ASSERT_NOW(a_col_order, state_q == ST_WIN, oc_q <= hi_q, "output column past run end")
  `IC_ASSERT_NXT(a_run_end, out_ld && out_rsp_d.last_of_run, state_q == ST_IDLE,
    "run end without return to idle")

endmodule
